// ===== hw/rtl/irpd_pkg.sv =====
// Shared types, codes and constants for the infrared pulse-distance frame decoder.
package irpd_pkg;

  localparam int unsigned FrameBitsDefault = 32;
  localparam int unsigned IntervalW        = 16;
  localparam int unsigned WinW             = 32;
  localparam int unsigned HalfW            = 16;
  localparam int unsigned MatchW           = 24;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 32;
  localparam int unsigned WordW            = 32;

  localparam logic [MatchW-1:0] MatchCodeReset = 24'h00BF15;
  localparam logic [ByteW-1:0]  KeyCheckAll    = 8'hFF;

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_BUTTON  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_BIT         = 3'd0,
    ST_FRAME_OK    = 3'd1,
    ST_TIMING_ERR  = 3'd2,
    ST_CHECK_FAIL  = 3'd3,
    ST_REPEAT      = 3'd4,
    ST_START       = 3'd5,
    ST_TIMEOUT     = 3'd6,
    ST_BUTTON      = 3'd7
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_WIN  = 3'd0,
    CFG_REPEAT_WIN = 3'd1,
    CFG_ZERO_WIN   = 3'd2,
    CFG_ONE_WIN    = 3'd3,
    CFG_MATCH_CODE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [WinW-1:0] start;
    logic [WinW-1:0] rpt;
    logic [WinW-1:0] zero;
    logic [WinW-1:0] one;
  } windows_t;

  typedef struct packed {
    logic start;
    logic rpt;
    logic zero;
    logic one;
  } win_hit_t;

  // Packed so that address_high lands in the lowest bits.
  typedef struct packed {
    logic [ByteW-1:0] repeat_count;
    logic             output_level;
    logic             code_matched;
    logic [ByteW-1:0] key_inverse;
    logic [ByteW-1:0] key_code;
    logic [ByteW-1:0] address_low;
    logic [ByteW-1:0] address_high;
  } result_t;

  // True when x lies strictly between the minimum (low half) and maximum (high half).
  function automatic logic in_window(logic [WinW-1:0] win, logic [IntervalW-1:0] x);
    return (x > win[HalfW-1:0]) && (x < win[WinW-1:HalfW]);
  endfunction

endpackage

// ===== hw/rtl/irpd_classify.sv =====
// Window comparators that classify one edge interval against the four timing windows.
module irpd_classify
  import irpd_pkg::*;
(
  input  windows_t               windows_i,
  input  logic [IntervalW-1:0]   interval_i,
  output win_hit_t               hit_o
);

  assign hit_o.start = in_window(windows_i.start, interval_i);
  assign hit_o.rpt   = in_window(windows_i.rpt,   interval_i);
  assign hit_o.zero  = in_window(windows_i.zero,  interval_i);
  assign hit_o.one   = in_window(windows_i.one,   interval_i);

endmodule

// ===== hw/rtl/irpd_decode.sv =====
// Frame state, per-item decode and the result register of the infrared decoder.
module irpd_decode
  import irpd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FrameBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          op_i,
  input  win_hit_t            hit_i,
  input  logic [MatchW-1:0]   match_code_i,
  input  logic                out_ready_i,
  output logic                take_o,
  output logic                out_valid_o,
  output status_e             status_o,
  output result_t             result_o
);

  localparam int unsigned IdxW = $clog2(FRAME_BITS);
  localparam int unsigned CntW = $clog2(FRAME_BITS + 1);
  localparam logic [CntW-1:0] IdxClosed = CntW'(FRAME_BITS);

  logic [FRAME_BITS-1:0] frame_q, frame_d, frame_set;
  logic [CntW-1:0]       idx_q, idx_d, idx_inc;
  logic                  bad_q, bad_d, bad_new;
  logic [ByteW-1:0]      rep_q, rep_d;
  logic                  pin_q, pin_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_new;
  result_t               result_q, result_new;
  logic                  has_res;
  logic                  bit_one;
  logic [WordW-1:0]      frame_ext;
  logic [ByteW-1:0]      b0, b1, b2, b3;

  assign take_o = in_valid_i && (!out_valid_q || out_ready_i);

  // A bit inside both windows counts as zero; outside both it is a timing error.
  assign bit_one   = !hit_i.zero && hit_i.one;
  assign bad_new   = bad_q || (!hit_i.zero && !hit_i.one);
  assign frame_set = frame_q | (FRAME_BITS'(bit_one) << idx_q[IdxW-1:0]);
  assign idx_inc   = idx_q + 1'b1;
  assign frame_ext = WordW'(frame_set);
  assign b0 = frame_ext[ByteW-1:0];
  assign b1 = frame_ext[2*ByteW-1:ByteW];
  assign b2 = frame_ext[3*ByteW-1:2*ByteW];
  assign b3 = frame_ext[4*ByteW-1:3*ByteW];

  always_comb begin
    frame_d    = frame_q;
    idx_d      = idx_q;
    bad_d      = bad_q;
    rep_d      = rep_q;
    pin_d      = pin_q;
    has_res    = 1'b0;
    status_new = ST_BIT;
    result_new = '0;
    if (take_o) begin
      unique case (op_i)
        OP_EDGE: begin
          has_res = 1'b1;
          if (hit_i.start) begin
            frame_d    = '0;
            idx_d      = '0;
            bad_d      = 1'b0;
            rep_d      = '0;
            status_new = ST_START;
          end else if (hit_i.rpt) begin
            rep_d      = rep_q + 1'b1;
            status_new = ST_REPEAT;
          end else if (idx_q >= IdxClosed) begin
            // Data edge with no frame open leaves the state alone.
            status_new = ST_TIMING_ERR;
          end else begin
            frame_d    = frame_set;
            idx_d      = idx_inc;
            bad_d      = bad_new;
            status_new = ST_BIT;
            if (idx_inc >= IdxClosed) begin
              bad_d = 1'b0;
              if (bad_new) begin
                status_new = ST_TIMING_ERR;
              end else begin
                result_new.address_high = b0;
                result_new.address_low  = b1;
                result_new.key_code     = b2;
                result_new.key_inverse  = b3;
                if ((b2 | b3) == KeyCheckAll) begin
                  status_new = ST_FRAME_OK;
                  if ({b0, b1, b2} == match_code_i) begin
                    result_new.code_matched = 1'b1;
                    pin_d = !pin_q;
                  end
                end else begin
                  status_new = ST_CHECK_FAIL;
                end
              end
            end
          end
        end
        OP_TIMEOUT: begin
          has_res    = 1'b1;
          rep_d      = '0;
          idx_d      = IdxClosed;
          bad_d      = 1'b0;
          status_new = ST_TIMEOUT;
        end
        OP_BUTTON: begin
          has_res    = 1'b1;
          pin_d      = !pin_q;
          status_new = ST_BUTTON;
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
    result_new.output_level = pin_d;
    result_new.repeat_count = rep_d;
    out_valid_d = has_res ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      idx_q       <= IdxClosed;
      bad_q       <= 1'b0;
      rep_q       <= '0;
      pin_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      idx_q       <= idx_d;
      bad_q       <= bad_d;
      rep_q       <= rep_d;
      pin_q       <= pin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_res) begin
      status_q <= status_new;
      result_q <= result_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_o    = result_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxClosed)
    else $error("bit index beyond frame length");

  a_bytes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !(status_q == ST_FRAME_OK || status_q == ST_CHECK_FAIL)) |->
    (result_q.address_high == '0 && result_q.address_low == '0 &&
     result_q.key_code == '0 && result_q.key_inverse == '0))
    else $error("byte fields set on a result without a completed frame");

  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.code_matched) |-> (status_q == ST_FRAME_OK))
    else $error("code match reported on a frame that did not pass");

  a_pin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> $stable(pin_q))
    else $error("output level changed without a taken item");
`endif

endmodule

// ===== hw/rtl/ir_pulse_distance_frame_decoder_core.sv =====
// Top level of the infrared pulse-distance frame decoder: ports, configuration and input register.
// Path: an item accepted into the input register is decoded from there into the result register,
//   which offers it on the output; a stalled output holds items back in both registers.
// Throughput: one item per cycle while the output is not stalled; decode updates the frame state.
// Reset clears all frame state, sets the output level high, closes any frame and loads the
//   configuration registers with their defaults; the block accepts items right after reset.
module ir_pulse_distance_frame_decoder_core
  import irpd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FrameBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,   // interval[15:0]
  input  logic [1:0]          s_axis_tuser_i,   // opcode[1:0]
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [47:0]         m_axis_tdata_o,   // address_high[7:0], address_low[15:8],
                                                // key_code[23:16], key_inverse[31:24],
                                                // code_matched[32], output_level[33],
                                                // repeat_count[41:34], zero fill
  output logic [2:0]          m_axis_tuser_o    // status[2:0]
);

  localparam int unsigned ResW = $bits(result_t);

  windows_t             win_q;
  logic [MatchW-1:0]    match_q;
  logic                 in_valid_q;
  logic [1:0]           op_q;
  logic [IntervalW-1:0] iv_q;
  logic                 take;
  logic                 in_accept;
  win_hit_t             hit;
  status_e              status;
  result_t              result;

  // Configuration registers: the user must write only while idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      match_q <= MatchCodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_WIN:  win_q.start <= cfg_data_i;
        CFG_REPEAT_WIN: win_q.rpt   <= cfg_data_i;
        CFG_ZERO_WIN:   win_q.zero  <= cfg_data_i;
        CFG_ONE_WIN:    win_q.one   <= cfg_data_i;
        CFG_MATCH_CODE: match_q     <= cfg_data_i[MatchW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input register frees up in the same cycle its item moves into decode,
  // so a stalled result only backs up the input once both stages are full.
  assign s_axis_tready_o = !in_valid_q || take;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= s_axis_tuser_i;
      iv_q <= s_axis_tdata_i;
    end
  end

  irpd_classify u_classify (
    .windows_i  (win_q),
    .interval_i (iv_q),
    .hit_o      (hit)
  );

  // Decode holds the frame state and the result register. An item with the
  // unused opcode is consumed there without producing a result.
  irpd_decode #(
    .FRAME_BITS (FRAME_BITS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_q),
    .op_i         (op_q),
    .hit_i        (hit),
    .match_code_i (match_q),
    .out_ready_i  (m_axis_tready_i),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid_o),
    .status_o     (status),
    .result_o     (result)
  );

  assign m_axis_tdata_o = {(48 - ResW)'(0), result};
  assign m_axis_tuser_o = status;

endmodule

// ===== verif/ir_pulse_distance_frame_decoder_core_tb.sv =====
// Self-checking testbench for the infrared pulse-distance frame decoder core.
module ir_pulse_distance_frame_decoder_core_tb;
  import irpd_pkg::*;

  // Opcode 3 has no operation behind it; the core swallows it without a result.
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned FrameLen   = FrameBitsDefault;
  localparam int unsigned NoPos      = 99;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 45;
  localparam int unsigned NumPhases  = 8;

  typedef struct packed {
    status_e status;
    result_t body;
  } decode_report_t;

  typedef enum logic [1:0] {
    ROW_EVENT,
    ROW_WRITE,
    ROW_FRAME
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [15:0] iv;
    cfg_idx_e    idx;
    logic [31:0] val;
    int unsigned bad_at;
    bit          typed;
    status_e     st;
    logic        lvl;
    logic [7:0]  rpt;
  } plan_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [15:0]         s_axis_tdata_i  = '0;   // interval[15:0]
  logic [1:0]          s_axis_tuser_i  = '0;   // opcode[1:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [47:0]         m_axis_tdata_o;         // address_high, address_low, key_code,
                                               // key_inverse, code_matched, output_level,
                                               // repeat_count, zero fill
  logic [2:0]          m_axis_tuser_o;         // status[2:0]

  ir_pulse_distance_frame_decoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, kept in step with every write.
  logic [31:0] win_start  = '0;
  logic [31:0] win_repeat = '0;
  logic [31:0] win_zero   = '0;
  logic [31:0] win_one    = '0;
  logic [23:0] match_word = MatchCodeReset;

  // Shadow of the decoder state. A frame position of FrameLen means no frame is open.
  logic [31:0] shift_bits    = '0;
  int unsigned frame_pos     = FrameLen;
  bit          frame_garbled = 1'b0;
  logic [7:0]  repeat_tally  = '0;
  logic        pin_state     = 1'b1;

  decode_report_t pending_reports[$];
  plan_row_t      plan[$];
  int unsigned    mismatches  = 0;
  int unsigned    events_sent = 0;
  int unsigned    cycle_count = 0;
  int unsigned    rx_hold     = 0;
  bit             tx_steady   = 1'b0;
  bit             rx_steady   = 1'b0;

  function automatic bit strictly_inside(logic [31:0] win, logic [15:0] x);
    return (x > win[15:0]) && (x < win[31:16]);
  endfunction

  // Works out the report for one accepted event and advances the shadow state.
  // Returns 0 for the unused opcode, which produces nothing.
  function automatic bit predict_event(input logic [1:0] op, input logic [15:0] iv,
                                       output decode_report_t rep);
    logic [7:0] b0, b1, b2, b3;
    rep.status = ST_BIT;
    rep.body   = '0;
    if (op == OP_UNUSED) return 1'b0;
    case (op)
      OP_EDGE: begin
        if (strictly_inside(win_start, iv)) begin
          shift_bits    = '0;
          frame_pos     = 0;
          frame_garbled = 1'b0;
          repeat_tally  = '0;
          rep.status    = ST_START;
        end else if (strictly_inside(win_repeat, iv)) begin
          repeat_tally = repeat_tally + 8'd1;
          rep.status   = ST_REPEAT;
        end else if (frame_pos >= FrameLen) begin
          // A data gap with no frame open changes nothing.
          rep.status = ST_TIMING_ERR;
        end else begin
          // The zero window wins when both windows hold the gap.
          if (!strictly_inside(win_zero, iv)) begin
            if (strictly_inside(win_one, iv)) shift_bits[frame_pos] = 1'b1;
            else frame_garbled = 1'b1;
          end
          frame_pos++;
          rep.status = ST_BIT;
          if (frame_pos >= FrameLen) begin
            if (frame_garbled) begin
              rep.status = ST_TIMING_ERR;
            end else begin
              b0 = shift_bits[7:0];
              b1 = shift_bits[15:8];
              b2 = shift_bits[23:16];
              b3 = shift_bits[31:24];
              rep.body.address_high = b0;
              rep.body.address_low  = b1;
              rep.body.key_code     = b2;
              rep.body.key_inverse  = b3;
              if ((b2 | b3) == KeyCheckAll) begin
                rep.status = ST_FRAME_OK;
                if (b0 == match_word[23:16] && b1 == match_word[15:8] &&
                    b2 == match_word[7:0]) begin
                  rep.body.code_matched = 1'b1;
                  pin_state = ~pin_state;
                end
              end else begin
                rep.status = ST_CHECK_FAIL;
              end
            end
            frame_garbled = 1'b0;
          end
        end
      end
      OP_TIMEOUT: begin
        repeat_tally  = '0;
        frame_pos     = FrameLen;
        frame_garbled = 1'b0;
        rep.status    = ST_TIMEOUT;
      end
      default: begin
        pin_state  = ~pin_state;
        rep.status = ST_BUTTON;
      end
    endcase
    rep.body.output_level = pin_state;
    rep.body.repeat_count = repeat_tally;
    return 1'b1;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A gap strictly inside the window, or any gap when the window is empty.
  function automatic logic [15:0] pick_inside(logic [31:0] win);
    if (win[31:16] > win[15:0] + 1)
      return 16'($urandom_range(win[15:0] + 1, win[31:16] - 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  // A gap that misses every window, where one can be found quickly.
  function automatic logic [15:0] pick_outside();
    logic [15:0] v;
    for (int i = 0; i < 32; i++) begin
      v = 16'($urandom_range(0, 65535));
      if (!strictly_inside(win_start, v) && !strictly_inside(win_repeat, v) &&
          !strictly_inside(win_zero, v) && !strictly_inside(win_one, v)) return v;
    end
    return 16'd0;
  endfunction

  // Frame contents: half of them aimed at the current match code, the rest with a
  // valid or random key check.
  function automatic logic [31:0] pick_word();
    int unsigned roll;
    logic [7:0]  key;
    roll = $urandom_range(0, 99);
    key  = 8'($urandom_range(0, 255));
    if (roll < 50) return {~match_word[7:0], match_word[7:0], match_word[15:8], match_word[23:16]};
    if (roll < 75) return {~key | 8'($urandom_range(0, 255)), key, 16'($urandom_range(0, 65535))};
    return $urandom;
  endfunction

  function automatic plan_row_t row_event(logic [1:0] op, logic [15:0] iv);
    plan_row_t r;
    r = '{kind: ROW_EVENT, op: op, iv: iv, idx: CFG_START_WIN, val: '0, bad_at: NoPos,
          typed: 1'b0, st: ST_BIT, lvl: 1'b0, rpt: '0};
    return r;
  endfunction

  function automatic plan_row_t row_checked(logic [1:0] op, logic [15:0] iv, status_e st,
                                            logic lvl, logic [7:0] rpt);
    plan_row_t r;
    r       = row_event(op, iv);
    r.typed = 1'b1;
    r.st    = st;
    r.lvl   = lvl;
    r.rpt   = rpt;
    return r;
  endfunction

  function automatic plan_row_t row_write(cfg_idx_e idx, logic [31:0] val);
    plan_row_t r;
    r      = row_event(OP_EDGE, '0);
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic plan_row_t row_frame(logic [31:0] word, int unsigned bad_at);
    plan_row_t r;
    r        = row_event(OP_EDGE, '0);
    r.kind   = ROW_FRAME;
    r.val    = word;
    r.bad_at = bad_at;
    return r;
  endfunction

  // Presents one item, holds it until the core takes it, then records what should
  // come back. A typed expectation replaces the predicted fields but the shadow
  // state still advances through the predictor.
  task automatic send_event(input logic [1:0] op, input logic [15:0] iv,
                            input bit typed = 1'b0, input status_e st = ST_BIT,
                            input logic lvl = 1'b0, input logic [7:0] rpt = '0);
    decode_report_t rep;
    int unsigned    gap;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= iv;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_event(op, iv, rep)) begin
      if (typed) begin
        rep.status            = st;
        rep.body              = '0;
        rep.body.output_level = lvl;
        rep.body.repeat_count = rpt;
      end
      pending_reports.push_back(rep);
      events_sent++;
    end
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_noise();
    logic [15:0] iv;
    case ($urandom_range(0, 3))
      0: iv = pick_inside(win_start);
      1: iv = pick_inside(win_repeat);
      2: iv = pick_inside($urandom_range(0, 1) ? win_zero : win_one);
      default: iv = 16'($urandom_range(0, 65535));
    endcase
    send_event(2'($urandom_range(0, 3)), iv);
  endtask

  // A start gap followed by nbits data gaps. The bit at bad_at gets a gap outside
  // every window, and a random event is slipped in before the bit at poke_at.
  task automatic send_frame(input logic [31:0] word, input int unsigned nbits,
                            input int unsigned bad_at, input int unsigned poke_at);
    logic [15:0] iv;
    send_event(OP_EDGE, pick_inside(win_start));
    for (int unsigned i = 0; i < nbits; i++) begin
      if (i == poke_at) send_noise();
      if (i == bad_at) iv = pick_outside();
      else iv = pick_inside(word[i] ? win_one : win_zero);
      send_event(OP_EDGE, iv);
    end
  endtask

  // Stops the input side and lets every outstanding item drain, then waits on so that
  // an ignored item that may still be in the pipeline can pass through.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_WIN:  win_start  = val;
      CFG_REPEAT_WIN: win_repeat = val;
      CFG_ZERO_WIN:   win_zero   = val;
      CFG_ONE_WIN:    win_one    = val;
      default:        match_word = val[23:0];
    endcase
    @(posedge clk_i);
  endtask

  // Programs all five registers for one random phase.
  //   flavor 0: nominal remote timing
  //   flavor 1: random disjoint windows, the start window sometimes open to the top
  //   flavor 2: data windows at the very ends of the interval range
  //   flavor 3: overlapping zero/one and repeat/start windows
  //   flavor 4: no start or repeat gap can hit, so frames never open
  task automatic program_phase(input int unsigned flavor);
    int unsigned u, zl, zh, ol, oh, rl, rh, sl, sh;
    logic [23:0] code;
    u  = $urandom_range(2, 250);
    zl = $urandom_range(0, 200);
    zh = zl + u;
    ol = zh + $urandom_range(0, 3);
    oh = ol + u;
    rl = oh + $urandom_range(0, 20);
    rh = rl + 4 * u;
    sl = rh + $urandom_range(0, 20);
    sh = ($urandom_range(0, 3) == 0) ? 32'hFFFF : sl + 5 * u;
    quiesce();
    case (flavor)
      0: begin
        write_reg(CFG_START_WIN,  {16'd140, 16'd100});
        write_reg(CFG_REPEAT_WIN, {16'd100, 16'd80});
        write_reg(CFG_ZERO_WIN,   {16'd15, 16'd5});
        write_reg(CFG_ONE_WIN,    {16'd25, 16'd15});
      end
      1: begin
        write_reg(CFG_ONE_WIN,    {oh[15:0], ol[15:0]});
        write_reg(CFG_START_WIN,  {sh[15:0], sl[15:0]});
        write_reg(CFG_ZERO_WIN,   {zh[15:0], zl[15:0]});
        write_reg(CFG_REPEAT_WIN, {rh[15:0], rl[15:0]});
      end
      2: begin
        write_reg(CFG_START_WIN,  {16'h8100, 16'h8000});
        write_reg(CFG_REPEAT_WIN, {16'h7100, 16'h7000});
        write_reg(CFG_ZERO_WIN,   {16'h0002, 16'h0000});
        write_reg(CFG_ONE_WIN,    {16'hFFFF, 16'hFFFD});
      end
      3: begin
        write_reg(CFG_START_WIN,  {16'd250, 16'd150});
        write_reg(CFG_REPEAT_WIN, {16'd200, 16'd100});
        write_reg(CFG_ZERO_WIN,   {16'd30, 16'd5});
        write_reg(CFG_ONE_WIN,    {16'd40, 16'd15});
      end
      default: begin
        write_reg(CFG_START_WIN,  {16'h0000, 16'hFFFF});
        write_reg(CFG_REPEAT_WIN, 32'hFFFF_FFFF);
        write_reg(CFG_ZERO_WIN,   {16'd15, 16'd5});
        write_reg(CFG_ONE_WIN,    {16'd25, 16'd15});
      end
    endcase
    case ($urandom_range(0, 4))
      0:       code = '0;
      1:       code = 24'hFF_FFFF;
      default: code = 24'($urandom_range(0, 24'hFF_FFFF));
    endcase
    // The top byte of the data is beyond the register and must be dropped.
    write_reg(CFG_MATCH_CODE, {8'($urandom_range(0, 255)), code});
  endtask

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result side: random back-pressure, with whole phases of steady readiness.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold         <= rx_hold - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_hold         <= pick_gap(rx_steady);
    end
  end

  // Every accepted result is checked against the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    decode_report_t want;
    result_t        got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o[41:0]);
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, m_axis_tuser_o);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", {5'd0, want.status}, {5'd0, m_axis_tuser_o});
        compare_field("address_high", want.body.address_high, got.address_high);
        compare_field("address_low", want.body.address_low, got.address_low);
        compare_field("key_code", want.body.key_code, got.key_code);
        compare_field("key_inverse", want.body.key_inverse, got.key_inverse);
        compare_field("code_matched", {7'd0, want.body.code_matched}, {7'd0, got.code_matched});
        compare_field("output_level", {7'd0, want.body.output_level}, {7'd0, got.output_level});
        compare_field("repeat_count", want.body.repeat_count, got.repeat_count);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[ir_pulse_distance_frame_decoder_core] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start, roll, nrep;

    // Directed part. Right after reset every window is empty, so each edge is a
    // timing error with no frame open, and only the pin moves.
    plan.push_back(row_checked(OP_EDGE, 16'h0000, ST_TIMING_ERR, 1'b1, 8'd0));
    plan.push_back(row_checked(OP_EDGE, 16'hFFFF, ST_TIMING_ERR, 1'b1, 8'd0));
    plan.push_back(row_checked(OP_TIMEOUT, 16'hFFFF, ST_TIMEOUT, 1'b1, 8'd0));
    plan.push_back(row_checked(OP_BUTTON, 16'h0000, ST_BUTTON, 1'b0, 8'd0));
    plan.push_back(row_event(OP_UNUSED, 16'hFFFF));
    plan.push_back(row_checked(OP_BUTTON, 16'h5555, ST_BUTTON, 1'b1, 8'd0));
    // Nominal timing; the default match code is written back with junk above it.
    plan.push_back(row_write(CFG_START_WIN, {16'd140, 16'd100}));
    plan.push_back(row_write(CFG_REPEAT_WIN, {16'd100, 16'd80}));
    plan.push_back(row_write(CFG_ZERO_WIN, {16'd15, 16'd5}));
    plan.push_back(row_write(CFG_ONE_WIN, {16'd25, 16'd15}));
    plan.push_back(row_write(CFG_MATCH_CODE, {8'h5A, MatchCodeReset}));
    // Repeats count even outside a frame; a gap equal to a window minimum misses it.
    plan.push_back(row_checked(OP_EDGE, 16'd90, ST_REPEAT, 1'b1, 8'd1));
    plan.push_back(row_checked(OP_EDGE, 16'd90, ST_REPEAT, 1'b1, 8'd2));
    plan.push_back(row_checked(OP_EDGE, 16'd100, ST_TIMING_ERR, 1'b1, 8'd2));
    plan.push_back(row_checked(OP_EDGE, 16'd120, ST_START, 1'b1, 8'd0));
    // A frame that matches the code flips the pin; afterwards no frame is open.
    plan.push_back(row_frame({~MatchCodeReset[7:0], MatchCodeReset[7:0],
                              MatchCodeReset[15:8], MatchCodeReset[23:16]}, NoPos));
    plan.push_back(row_checked(OP_EDGE, 16'd10, ST_TIMING_ERR, 1'b0, 8'd0));
    // Failed key check, then a frame spoiled on its last bit.
    plan.push_back(row_frame(32'h0000_BF00, NoPos));
    plan.push_back(row_frame(32'hEA15_BF00, FrameLen - 1));
    // A timeout in the middle of a frame abandons it.
    plan.push_back(row_event(OP_EDGE, 16'd120));
    plan.push_back(row_event(OP_EDGE, 16'd10));
    plan.push_back(row_checked(OP_TIMEOUT, 16'd0, ST_TIMEOUT, 1'b0, 8'd0));
    plan.push_back(row_checked(OP_EDGE, 16'd20, ST_TIMING_ERR, 1'b0, 8'd0));
    // Overlapping data windows: every one bit lands in the zero window first.
    plan.push_back(row_write(CFG_ZERO_WIN, {16'd30, 16'd5}));
    plan.push_back(row_frame(32'hEA15_BF00, NoPos));
    // Match code extremes.
    plan.push_back(row_write(CFG_ZERO_WIN, {16'd15, 16'd5}));
    plan.push_back(row_write(CFG_MATCH_CODE, 32'hFFFF_FFFF));
    plan.push_back(row_frame(32'h00FF_FFFF, NoPos));
    plan.push_back(row_write(CFG_MATCH_CODE, 32'h0000_0000));
    plan.push_back(row_frame(32'hFF00_0000, NoPos));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          quiesce();
          write_reg(plan[i].idx, plan[i].val);
        end
        ROW_FRAME: send_frame(plan[i].val, FrameLen, plan[i].bad_at, NoPos);
        default: send_event(plan[i].op, plan[i].iv, plan[i].typed, plan[i].st,
                            plan[i].lvl, plan[i].rpt);
      endcase
    end

    // Random part: phases of fresh configuration, each mostly well-formed frames
    // with random contents, plus broken frames, repeat bursts and loose noise.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      program_phase(p % 5);
      tx_steady   = ($urandom_range(0, 3) == 0);
      rx_steady   = ($urandom_range(0, 3) == 0);
      phase_start = events_sent;
      while (events_sent - phase_start < PhaseItems) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          send_frame(pick_word(), FrameLen, NoPos, NoPos);
          nrep = $urandom_range(0, 3);
          repeat (nrep) send_event(OP_EDGE, pick_inside(win_repeat));
        end else if (roll < 70) begin
          send_frame(pick_word(), $urandom_range(0, FrameLen), $urandom_range(0, 63),
                     $urandom_range(0, 40));
        end else if (roll < 78) begin
          // Long bursts carry the repeat count past its wrap.
          nrep = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 6);
          repeat (nrep) send_event(OP_EDGE, pick_inside(win_repeat));
        end else begin
          send_noise();
        end
      end
    end

    tx_steady = 1'b0;
    quiesce();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ir_pulse_distance_frame_decoder_core] OK");
    end else begin
      $display("[ir_pulse_distance_frame_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
